### hw/rtl/rbs_pkg.sv
// Package for the ray / box slab intersection block.
// Holds the fixed-point widths, the divider stage record and the small
// arithmetic helpers. Depends on nothing.
package rbs_pkg;

    localparam int QW        = 32;
    localparam int HW        = 31;
    localparam int DIV_STEPS = QW + 1;

    localparam logic signed [QW-1:0] Q_NEG_ONE = 32'shFFFF0000;
    localparam logic signed [QW-1:0] S32_MAX   = 32'sh7FFFFFFF;
    localparam logic signed [QW-1:0] S32_MIN   = 32'sh80000000;

    localparam logic signed [1:0] NRM_POS  = 2'sb01;
    localparam logic signed [1:0] NRM_NEG  = 2'sb11;
    localparam logic signed [1:0] NRM_ZERO = 2'sb00;

    // One lane of the reciprocal divider, 2^32 / |d|, restoring form.
    typedef struct packed {
        logic [QW:0]   rem;
        logic [QW:0]   quo;
        logic [QW-1:0] dvs;
        logic          neg;
        logic          zero;
    } t_div;

    function automatic t_div div_step(t_div s, logic bit_in);
        t_div          r;
        logic [QW:0]   rem_sh;
        logic [QW+1:0] diff;
        r      = s;
        rem_sh = {s.rem[QW-1:0], bit_in};
        diff   = {1'b0, rem_sh} - {2'b00, s.dvs};
        if (!diff[QW+1]) begin
            r.rem = diff[QW:0];
            r.quo = {s.quo[QW-1:0], 1'b1};
        end else begin
            r.rem = rem_sh;
            r.quo = {s.quo[QW-1:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic signed [QW-1:0] sat48(logic signed [47:0] v);
        logic signed [QW-1:0] r;
        r = v[QW-1:0];
        if (!v[47] && (|v[46:QW-1])) begin
            r = S32_MAX;
        end else if (v[47] && !(&v[46:QW-1])) begin
            r = S32_MIN;
        end
        return r;
    endfunction

    function automatic logic signed [QW-1:0] sat34(logic signed [QW+1:0] v);
        logic signed [QW-1:0] r;
        r = v[QW-1:0];
        if (!v[QW+1] && (|v[QW:QW-1])) begin
            r = S32_MAX;
        end else if (v[QW+1] && !(&v[QW:QW-1])) begin
            r = S32_MIN;
        end
        return r;
    endfunction

endpackage

### hw/rtl/rbs_if.sv
// Stream interfaces of the ray / box slab intersection block.
// Uses no package; one interface carries rays in, the other results out.
interface rbs_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   origin_x;
    logic signed [31:0]   origin_y;
    logic signed [31:0]   origin_z;
    logic signed [31:0]   dir_x;
    logic signed [31:0]   dir_y;
    logic signed [31:0]   dir_z;
    logic        [30:0]   half_x;
    logic        [30:0]   half_y;
    logic        [30:0]   half_z;

    modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   half_x, half_y, half_z, input ready);
    modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 half_x, half_y, half_z, output ready);
endinterface

interface rbs_out_if;
    logic                valid;
    logic                ready;
    logic                hit;
    logic signed [31:0]  t_near;
    logic signed [31:0]  t_far;
    logic signed [1:0]   normal_x;
    logic signed [1:0]   normal_y;
    logic signed [1:0]   normal_z;

    modport source(output valid, hit, t_near, t_far, normal_x, normal_y, normal_z,
                   input ready);
    modport sink(input valid, hit, t_near, t_far, normal_x, normal_y, normal_z,
                 output ready);
endinterface

### hw/rtl/ray_box_slab_intersection.sv
// Ray / box slab intersection, top level.
// Depends on rbs_pkg and the stream interfaces in rbs_if.sv.

// Takes one ray word per cycle while the output is not stalled, and returns one
// result word per ray, in order. Each ray passes through the input capture
// register and the reciprocal divider, which resolves one quotient bit per stage
// over 33 stages. These are followed by stages for reciprocal sign fix-up, the
// multiplies, product scaling, slab distances, near/far reduction and the result
// register. The whole pipeline advances together and holds while a finished word
// waits at the output.
module ray_box_slab_intersection (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rbs_in_if.sink    i_ray,
    rbs_out_if.source o_res
);

    localparam int NS = rbs_pkg::DIV_STEPS;
    localparam int QW = rbs_pkg::QW;
    localparam int HW = rbs_pkg::HW;

    logic en;

    // Divider stages, payload carried alongside.
    rbs_pkg::t_div           r_dv [NS+1][3];
    logic signed [QW-1:0]    r_do [NS+1][3];
    logic        [HW-1:0]    r_dh [NS+1][3];
    logic                    r_dvld [NS+1];

    // Later stages.
    logic signed [QW-1:0]    r_m  [3];
    logic        [QW-1:0]    r_ma [3];
    logic signed [QW-1:0]    r_mo [3];
    logic        [HW-1:0]    r_mh [3];
    logic                    r_mneg [3];
    logic                    r_mzero [3];
    logic                    r_mvld;

    logic signed [63:0]      r_pn [3];
    logic        [62:0]      r_pk [3];
    logic                    r_pneg [3];
    logic                    r_pzero [3];
    logic                    r_pvld;

    logic signed [QW-1:0]    r_n [3];
    logic signed [QW-1:0]    r_k [3];
    logic                    r_sneg [3];
    logic                    r_szero [3];
    logic                    r_svld;

    logic signed [QW-1:0]    r_t1 [3];
    logic signed [QW-1:0]    r_t2 [3];
    logic                    r_tneg [3];
    logic                    r_tzero [3];
    logic                    r_tvld;

    logic signed [QW-1:0]    r_tn;
    logic signed [QW-1:0]    r_tf;
    logic signed [QW-1:0]    r_rt1 [3];
    logic                    r_rneg [3];
    logic                    r_rzero [3];
    logic                    r_rvld;

    logic                    r_ovld;
    logic                    r_hit;
    logic signed [QW-1:0]    r_tnear;
    logic signed [QW-1:0]    r_tfar;
    logic signed [1:0]       r_nrm [3];

    logic signed [QW-1:0]    in_o [3];
    logic signed [QW-1:0]    in_d [3];
    logic        [HW-1:0]    in_h [3];

    assign en          = !r_ovld || o_res.ready;
    assign i_ray.ready = en;

    assign in_o[0] = i_ray.origin_x;
    assign in_o[1] = i_ray.origin_y;
    assign in_o[2] = i_ray.origin_z;
    assign in_d[0] = i_ray.dir_x;
    assign in_d[1] = i_ray.dir_y;
    assign in_d[2] = i_ray.dir_z;
    assign in_h[0] = i_ray.half_x;
    assign in_h[1] = i_ray.half_y;
    assign in_h[2] = i_ray.half_z;

    // Capture stage: divisor is |d|, which also covers the most negative value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld[0] <= 1'b0;
        end else if (en) begin
            r_dvld[0] <= i_ray.valid;
        end
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_dv[0][a].rem  <= '0;
                r_dv[0][a].quo  <= '0;
                r_dv[0][a].dvs  <= in_d[a][QW-1] ? QW'(-in_d[a]) : QW'(in_d[a]);
                r_dv[0][a].neg  <= in_d[a][QW-1];
                r_dv[0][a].zero <= (in_d[a] == '0);
                r_do[0][a]      <= in_o[a];
                r_dh[0][a]      <= in_h[a];
            end
        end
    end

    // The dividend is 2^32: only the first step shifts in a one.
    for (genvar s = 0; s < NS; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[s+1] <= 1'b0;
            end else if (en) begin
                r_dvld[s+1] <= r_dvld[s];
            end
            if (en) begin
                for (int a = 0; a < 3; a++) begin
                    r_dv[s+1][a] <= rbs_pkg::div_step(r_dv[s][a], (s == 0));
                    r_do[s+1][a] <= r_do[s][a];
                    r_dh[s+1][a] <= r_dh[s][a];
                end
            end
        end
    end

    // Reciprocal sign fix-up and saturation.
    always_ff @(posedge i_clk) begin
        logic [QW:0] q;
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else if (en) begin
            r_mvld <= r_dvld[NS];
        end
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                q = r_dv[NS][a].quo;
                if (r_dv[NS][a].zero || (!r_dv[NS][a].neg && (|q[QW:QW-1]))) begin
                    r_m[a]  <= rbs_pkg::S32_MAX;
                    r_ma[a] <= QW'(rbs_pkg::S32_MAX);
                end else if (!r_dv[NS][a].neg) begin
                    r_m[a]  <= q[QW-1:0];
                    r_ma[a] <= q[QW-1:0];
                end else if (q > (QW+1)'(33'h080000000)) begin
                    r_m[a]  <= rbs_pkg::S32_MIN;
                    r_ma[a] <= QW'(rbs_pkg::S32_MIN);
                end else begin
                    r_m[a]  <= QW'(-q[QW-1:0]);
                    r_ma[a] <= q[QW-1:0];
                end
                r_mo[a]    <= r_do[NS][a];
                r_mh[a]    <= r_dh[NS][a];
                r_mneg[a]  <= r_dv[NS][a].neg;
                r_mzero[a] <= r_dv[NS][a].zero;
            end
        end
    end

    // Products m * origin and |m| * half.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else if (en) begin
            r_pvld <= r_mvld;
        end
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_pn[a]    <= 64'(r_m[a]) * 64'(r_mo[a]);
                r_pk[a]    <= 63'(r_ma[a]) * 63'(r_mh[a]);
                r_pneg[a]  <= r_mneg[a];
                r_pzero[a] <= r_mzero[a];
            end
        end
    end

    // Scale by 2^-16 (floor) and saturate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svld <= 1'b0;
        end else if (en) begin
            r_svld <= r_pvld;
        end
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_n[a] <= rbs_pkg::sat48(r_pn[a][63:16]);
                if (|r_pk[a][62:47]) begin
                    r_k[a] <= rbs_pkg::S32_MAX;
                end else begin
                    r_k[a] <= r_pk[a][47:16];
                end
                r_sneg[a]  <= r_pneg[a];
                r_szero[a] <= r_pzero[a];
            end
        end
    end

    // Slab entry and exit distances.
    always_ff @(posedge i_clk) begin
        logic signed [QW+1:0] nw;
        logic signed [QW+1:0] kw;
        if (!i_rst_n) begin
            r_tvld <= 1'b0;
        end else if (en) begin
            r_tvld <= r_svld;
        end
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                nw = (QW+2)'(r_n[a]);
                kw = (QW+2)'(r_k[a]);
                r_t1[a]    <= rbs_pkg::sat34(-nw - kw);
                r_t2[a]    <= rbs_pkg::sat34(kw - nw);
                r_tneg[a]  <= r_sneg[a];
                r_tzero[a] <= r_szero[a];
            end
        end
    end

    // Near is the largest entry, far the smallest exit.
    always_ff @(posedge i_clk) begin
        logic signed [QW-1:0] mx;
        logic signed [QW-1:0] mn;
        if (!i_rst_n) begin
            r_rvld <= 1'b0;
        end else if (en) begin
            r_rvld <= r_tvld;
        end
        if (en) begin
            mx = (r_t1[0] > r_t1[1]) ? r_t1[0] : r_t1[1];
            mn = (r_t2[0] < r_t2[1]) ? r_t2[0] : r_t2[1];
            r_tn <= (mx > r_t1[2]) ? mx : r_t1[2];
            r_tf <= (mn < r_t2[2]) ? mn : r_t2[2];
            for (int a = 0; a < 3; a++) begin
                r_rt1[a]   <= r_t1[a];
                r_rneg[a]  <= r_tneg[a];
                r_rzero[a] <= r_tzero[a];
            end
        end
    end

    // Hit decision and entry face normal.
    always_ff @(posedge i_clk) begin
        logic hit;
        logic top;
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_rvld;
        end
        if (en) begin
            hit = !((r_tn > r_tf) || r_tf[QW-1]);
            r_hit   <= hit;
            r_tnear <= hit ? r_tn : rbs_pkg::Q_NEG_ONE;
            r_tfar  <= hit ? r_tf : rbs_pkg::Q_NEG_ONE;
            for (int a = 0; a < 3; a++) begin
                top = (r_rt1[a] > r_rt1[(a+1)%3]) && (r_rt1[a] > r_rt1[(a+2)%3]);
                if (!hit || !top || r_rzero[a]) begin
                    r_nrm[a] <= rbs_pkg::NRM_ZERO;
                end else if (r_rneg[a]) begin
                    r_nrm[a] <= rbs_pkg::NRM_POS;
                end else begin
                    r_nrm[a] <= rbs_pkg::NRM_NEG;
                end
            end
        end
    end

    assign o_res.valid    = r_ovld;
    assign o_res.hit      = r_hit;
    assign o_res.t_near   = r_tnear;
    assign o_res.t_far    = r_tfar;
    assign o_res.normal_x = r_nrm[0];
    assign o_res.normal_y = r_nrm[1];
    assign o_res.normal_z = r_nrm[2];

endmodule
